// File: sv/rtpm_pkg.sv
// ----------------------------------------------------------------------------
// RTP-MIDI command parser package
// Beat payload types, parse phase encoding, status classification and the
// helper that picks the phase which follows a length field or a command.
// ----------------------------------------------------------------------------
package rtpm_pkg;

	localparam int RTPM_HEADER_BYTES = 12;
	localparam int RTPM_SYSEX_LIMIT  = 128;

	localparam logic [1:0] RK_MSG   = 2'd0;
	localparam logic [1:0] RK_SYSEX = 2'd1;
	localparam logic [1:0] RK_ABORT = 2'd2;

	localparam logic [7:0] FLAG_B      = 8'h80;
	localparam logic [7:0] FLAG_Z      = 8'h20;
	localparam logic [7:0] STAT_SYSEX  = 8'hF0;
	localparam logic [7:0] STAT_EOX    = 8'hF7;
	localparam logic [2:0] DELTA_MAX   = 3'd4;

	// status classes: number of data bytes, sysex start or unknown
	localparam logic [2:0] CLS_NONE  = 3'd0;
	localparam logic [2:0] CLS_ONE   = 3'd1;
	localparam logic [2:0] CLS_TWO   = 3'd2;
	localparam logic [2:0] CLS_SYSEX = 3'd3;
	localparam logic [2:0] CLS_BAD   = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_LENLOW,
		PH_DELTA,
		PH_CMD,
		PH_DATA,
		PH_SYSEX,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} rtpm_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  msg_type;
		logic [4:0]  channel;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
		logic [7:0]  byte_count;
		logic [31:0] stamp;
		logic [7:0]  sysex_byte;
		logic [7:0]  sysex_index;
		logic        sysex_end;
	} rtpm_out_t;

	function automatic logic [2:0] rtpm_classify(input logic [7:0] s);
		logic [2:0] c;
		c = CLS_BAD;
		if (s[7] == 1'b0) begin
			c = CLS_BAD;
		end else if (s[7:4] != 4'hF) begin
			c = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? CLS_ONE : CLS_TWO;
		end else begin
			case (s[3:0])
				4'h0:                                    c = CLS_SYSEX;
				4'h1, 4'h3:                              c = CLS_ONE;
				4'h2:                                    c = CLS_TWO;
				4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: c = CLS_NONE;
				default:                                 c = CLS_BAD;
			endcase
		end
		return c;
	endfunction

	// phase after the length field or after a finished command
	function automatic phase_t rtpm_next_cmd(input logic [11:0] len, input logic cs,
		input logic [7:0] flags);
		phase_t p;
		if (len == 12'd0) begin
			p = PH_IDLE;
		end else if (cs || (flags & FLAG_Z) != 8'd0) begin
			p = PH_DELTA;
		end else begin
			p = PH_CMD;
		end
		return p;
	endfunction

endpackage

// File: sv/rtp_midi_command_parser.sv
// ----------------------------------------------------------------------------
// RTP-MIDI command section parser
// Path: a byte is held in the input register, then the parse logic writes
// its result beat into the result register, which holds it until taken.
// Throughput: one byte per cycle while the result register is empty or being
// taken, set by the single-pass parse step.
// Reset: arst_n clears all parse state to idle and empties both registers.
// ----------------------------------------------------------------------------
//
// Takes packet bytes, one per beat, with packet_start on the first byte.
// Bytes 4 to 7 give the big-endian timestamp; the command-section header at
// byte HEADER_BYTES sets the length (B flag: 12-bit) and whether the first
// command carries a delta time (Z flag). Delta times are skipped, each MIDI
// command gives one result beat, and sysex bytes come out one beat each.
// Unknown status bytes and length overruns drop the packet with an abort beat.
//
// Flow: the input register advances into the parser whenever the result
// register is empty or being taken. A result beat that waits downstream holds
// the parser, and once the input register is full the input stalls too.
module rtp_midi_command_parser
	import rtpm_pkg::*;
#(
	parameter int HEADER_BYTES = RTPM_HEADER_BYTES,
	parameter int SYSEX_LIMIT  = RTPM_SYSEX_LIMIT
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  rtpm_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output rtpm_out_t result
);

	logic      valid_s1;
	rtpm_in_t  item_s1;
	logic      out_ready;
	logic      advance;
	logic      res_valid;
	rtpm_out_t res;

	// consume the held byte whenever the result side can take its outcome
	assign advance = valid_s1 && out_ready;

	rtpm_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	rtpm_parser #(
		.HEADER_BYTES (HEADER_BYTES),
		.SYSEX_LIMIT  (SYSEX_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// gate the result so that a held byte is never counted twice
	rtpm_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid && advance),
		.res          (res),
		.ready        (out_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_abort_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == RK_ABORT |->
		result.msg_type == 8'd0 && result.channel == 5'd0 && result.byte_count == 8'd0
		&& result.sysex_byte == 8'd0 && result.sysex_end == 1'b0)
		else $error("abort beat carries payload");

	a_sysex_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == RK_SYSEX |->
		result.msg_type == STAT_SYSEX && result.channel == 5'd0)
		else $error("sysex beat with wrong type or channel");

	a_msg_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == RK_MSG |->
		result.byte_count >= 8'd1 && result.byte_count <= 8'd3)
		else $error("message byte count out of range");

endmodule

// File: sv/rtpm_in_stage.sv
// ----------------------------------------------------------------------------
// RTP-MIDI input stage
// Registers one input beat and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module rtpm_in_stage
	import rtpm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  rtpm_in_t item,
	input  logic     advance,
	output logic     valid_s1,
	output rtpm_in_t item_s1
);

	logic load;

	assign item_stall = valid_s1 && !advance;
	assign load       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// File: sv/rtpm_parser.sv
// ----------------------------------------------------------------------------
// RTP-MIDI parser core
// Holds the parse state and works out the state update and the result of one
// packet byte in a single pass.
// ----------------------------------------------------------------------------
module rtpm_parser
	import rtpm_pkg::*;
#(
	parameter int HEADER_BYTES = RTPM_HEADER_BYTES,
	parameter int SYSEX_LIMIT  = RTPM_SYSEX_LIMIT
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  rtpm_in_t  item_s1,
	output logic      res_valid,
	output rtpm_out_t res
);

	phase_t      phase_q, phase_d, ph_e;
	logic [4:0]  pos_q, pos_d, pos_e;
	logic [7:0]  flags_q, flags_d, flags_e;
	logic [11:0] len_q, len_d, len_e, len_dec;
	logic [2:0]  delta_q, delta_d, delta_inc;
	logic [7:0]  status_q, status_d;
	logic [7:0]  first_q, first_d;
	logic [1:0]  need_q, need_d;
	logic [31:0] ts_q, ts_d;
	logic        cs_q, cs_d, cs_e;
	logic [7:0]  sxc_q, sxc_d;

	logic [7:0]  b;
	logic [2:0]  cls;
	logic [2:0]  cls_held;
	logic        do_sysex, do_after;
	logic [7:0]  sx_idx;
	logic [8:0]  sx_cnt;
	logic        at_f7, at_limit;

	assign b = item_s1.data_byte;

	always_comb begin
		ph_e    = phase_q;
		pos_e   = pos_q;
		cs_e    = cs_q;
		len_e   = len_q;
		flags_e = flags_q;
		if (item_s1.packet_start) begin
			ph_e    = PH_HEADER;
			pos_e   = '0;
			cs_e    = 1'b0;
			len_e   = '0;
			flags_e = '0;
		end

		len_dec   = len_e - 12'd1;
		delta_inc = delta_q + 3'd1;
		cls       = rtpm_classify(b);
		cls_held  = rtpm_classify(status_q);

		phase_d  = ph_e;
		pos_d    = pos_e;
		cs_d     = cs_e;
		len_d    = len_e;
		flags_d  = flags_e;
		delta_d  = delta_q;
		status_d = status_q;
		first_d  = first_q;
		need_d   = need_q;
		ts_d     = ts_q;
		sxc_d    = sxc_q;

		res_valid = 1'b0;
		res       = '0;
		res.stamp = ts_q;
		do_sysex  = 1'b0;
		do_after  = 1'b0;
		sx_idx    = sxc_q;

		case (ph_e)
			PH_HEADER: begin
				if (pos_e == 5'(HEADER_BYTES)) begin
					flags_d = b;
					len_d   = {8'd0, b[3:0]};
					if ((b & FLAG_B) != 8'd0) begin
						phase_d = PH_LENLOW;
					end else begin
						phase_d = rtpm_next_cmd({8'd0, b[3:0]}, cs_e, b);
						delta_d = '0;
					end
				end else begin
					if (pos_e >= 5'd4 && pos_e <= 5'd7) begin
						ts_d = {ts_q[23:0], b};
					end
					pos_d = pos_e + 5'd1;
				end
			end
			PH_LENLOW: begin
				len_d   = {len_e[3:0], b};
				phase_d = rtpm_next_cmd({len_e[3:0], b}, cs_e, flags_e);
				delta_d = '0;
			end
			PH_DELTA: begin
				len_d   = len_dec;
				delta_d = delta_inc;
				if (!b[7] || delta_inc >= DELTA_MAX) begin
					phase_d = (len_dec == 12'd0) ? PH_IDLE : PH_CMD;
				end else if (len_dec == 12'd0) begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.result_kind = RK_ABORT;
				end
			end
			PH_CMD: begin
				len_d    = len_dec;
				status_d = b;
				case (cls)
					CLS_BAD: begin
						phase_d         = PH_IDLE;
						res_valid       = 1'b1;
						res.result_kind = RK_ABORT;
					end
					CLS_SYSEX: begin
						sx_idx   = '0;
						do_sysex = 1'b1;
					end
					CLS_NONE: begin
						res_valid       = 1'b1;
						res.result_kind = RK_MSG;
						res.msg_type    = b;
						res.byte_count  = 8'd1;
						do_after        = 1'b1;
					end
					default: begin
						if ({9'd0, cls} > len_dec) begin
							phase_d         = PH_IDLE;
							res_valid       = 1'b1;
							res.result_kind = RK_ABORT;
						end else begin
							need_d  = cls[1:0];
							phase_d = PH_DATA;
						end
					end
				endcase
			end
			PH_DATA: begin
				len_d = len_dec;
				if (need_q >= 2'd2) begin
					first_d = b;
					need_d  = 2'd1;
				end else begin
					need_d          = 2'd0;
					res_valid       = 1'b1;
					res.result_kind = RK_MSG;
					res.msg_type    = (status_q[7:4] != 4'hF) ? {status_q[7:4], 4'h0} : status_q;
					res.channel     = (status_q[7:4] != 4'hF) ? ({1'b0, status_q[3:0]} + 5'd1)
					                                          : 5'd0;
					if (cls_held == CLS_TWO) begin
						res.data_one   = first_q;
						res.data_two   = b;
						res.byte_count = 8'd3;
					end else begin
						res.data_one   = b;
						res.byte_count = 8'd2;
					end
					do_after = 1'b1;
				end
			end
			PH_SYSEX: begin
				len_d    = len_dec;
				do_sysex = 1'b1;
			end
			PH_SKIP: begin
				len_d    = len_dec;
				do_after = 1'b1;
			end
			default: begin
				phase_d = ph_e;
			end
		endcase

		// one sysex byte: emit it, or drop the packet on a length overrun
		at_f7    = (b == STAT_EOX);
		at_limit = ({1'b0, sx_idx} + 9'd1) >= 9'(SYSEX_LIMIT);
		sx_cnt   = {1'b0, sx_idx} + 9'd1;
		if (!at_f7 && at_limit) begin
			sx_cnt = sx_cnt + 9'd1;
		end
		if (do_sysex) begin
			res_valid = 1'b1;
			if (!at_f7 && len_dec == 12'd0) begin
				phase_d         = PH_IDLE;
				res.result_kind = RK_ABORT;
			end else begin
				res.result_kind = RK_SYSEX;
				res.msg_type    = STAT_SYSEX;
				res.data_one    = sx_cnt[7:0];
				res.data_two    = {7'd0, sx_cnt[8]};
				res.byte_count  = sx_cnt[7:0];
				res.sysex_byte  = b;
				res.sysex_index = sx_idx;
				res.sysex_end   = at_f7 || at_limit;
				if (at_f7) begin
					do_after = 1'b1;
				end else if (at_limit) begin
					phase_d = PH_SKIP;
				end else begin
					sxc_d   = sx_idx + 8'd1;
					phase_d = PH_SYSEX;
				end
			end
		end

		if (do_after) begin
			cs_d    = 1'b1;
			phase_d = rtpm_next_cmd(len_d, 1'b1, flags_d);
			delta_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			flags_q  <= '0;
			len_q    <= '0;
			delta_q  <= '0;
			status_q <= '0;
			first_q  <= '0;
			need_q   <= '0;
			ts_q     <= '0;
			cs_q     <= 1'b0;
			sxc_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			flags_q  <= flags_d;
			len_q    <= len_d;
			delta_q  <= delta_d;
			status_q <= status_d;
			first_q  <= first_d;
			need_q   <= need_d;
			ts_q     <= ts_d;
			cs_q     <= cs_d;
			sxc_q    <= sxc_d;
		end
	end

	a_data_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> need_q != 2'd0)
		else $error("data phase with no data bytes outstanding");

	a_delta_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DELTA |-> delta_q < DELTA_MAX)
		else $error("delta time longer than four bytes");

	a_sysex_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SYSEX |-> {1'b0, sxc_q} < 9'(SYSEX_LIMIT))
		else $error("sysex run past its limit");

endmodule

// File: sv/rtpm_out_stage.sv
// ----------------------------------------------------------------------------
// RTP-MIDI result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module rtpm_out_stage
	import rtpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  rtpm_out_t res,
	output logic      ready,
	output logic      result_valid,
	input  logic      result_stall,
	output rtpm_out_t result
);

	logic      valid_q;
	rtpm_out_t result_q;

	assign ready        = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_valid) begin
			result_q <= res;
		end
	end

endmodule

// File: test/rtp_midi_command_parser_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP-MIDI command parser checker
// Watches both channels, decodes every accepted packet byte into the MIDI
// events it must give and compares each result beat with the oldest of them.
// ----------------------------------------------------------------------------
module rtp_midi_command_parser_check
	import rtpm_pkg::*;
#(
	parameter int HEADER_BYTES = RTPM_HEADER_BYTES,
	parameter int SYSEX_LIMIT  = RTPM_SYSEX_LIMIT
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_stall,
	input  rtpm_in_t  item,
	input  logic      result_valid,
	input  logic      result_stall,
	input  rtpm_out_t result,
	output int        mismatches,
	output int        events_due
);

	localparam int         STAMP_FIRST  = 4;
	localparam int         STAMP_LAST   = 7;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;
	localparam logic [7:0] ST_MTC       = 8'hF1;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_TUNE      = 8'hF6;
	localparam logic [7:0] ST_CLOCK     = 8'hF8;
	localparam logic [7:0] ST_START     = 8'hFA;
	localparam logic [7:0] ST_CONT      = 8'hFB;
	localparam logic [7:0] ST_STOP      = 8'hFC;
	localparam logic [7:0] ST_SENSE     = 8'hFE;
	localparam logic [7:0] ST_RESET     = 8'hFF;

	phase_t      phase;
	logic [4:0]  hdr_pos;
	logic [7:0]  sect_flags;
	logic [11:0] sect_left;
	logic [2:0]  delta_len;
	logic [7:0]  status_byte;
	logic [7:0]  first_data;
	logic [1:0]  data_left;
	logic [31:0] rtp_stamp;
	logic        cmd_done;
	logic [7:0]  sysex_pos;
	rtpm_out_t   midi_events_due[$];
	int          errs;

	function automatic logic [2:0] status_class(input logic [7:0] s);
		if (!s[7])
			return CLS_BAD;
		if (s[7:4] == NIB_PROGRAM || s[7:4] == NIB_PRESSURE)
			return CLS_ONE;
		if (s[7:4] != NIB_SYSTEM)
			return CLS_TWO;
		case (s)
			STAT_SYSEX:                  return CLS_SYSEX;
			ST_MTC, ST_SONG_SEL:         return CLS_ONE;
			ST_SONG_POS:                 return CLS_TWO;
			ST_TUNE, ST_CLOCK, ST_START, ST_CONT,
			ST_STOP, ST_SENSE, ST_RESET: return CLS_NONE;
			default:                     return CLS_BAD;
		endcase
	endfunction

	task automatic push_event(input logic [1:0] kind, input logic [7:0] mtype,
		input logic [4:0] ch, input logic [7:0] d1, input logic [7:0] d2,
		input logic [7:0] cnt, input logic [7:0] sx, input logic [7:0] sxi,
		input logic sxe);
		rtpm_out_t ev;
		ev.result_kind = kind;
		ev.msg_type    = mtype;
		ev.channel     = ch;
		ev.data_one    = d1;
		ev.data_two    = d2;
		ev.byte_count  = cnt;
		ev.stamp       = rtp_stamp;
		ev.sysex_byte  = sx;
		ev.sysex_index = sxi;
		ev.sysex_end   = sxe;
		midi_events_due.push_back(ev);
	endtask

	task automatic drop_packet();
		phase = PH_IDLE;
		push_event(RK_ABORT, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
	endtask

	task automatic next_command();
		if (sect_left == 12'd0) begin
			phase = PH_IDLE;
		end else if (cmd_done || (sect_flags & FLAG_Z) != 8'd0) begin
			phase = PH_DELTA;
			delta_len = 3'd0;
		end else begin
			phase = PH_CMD;
		end
	endtask

	task automatic finish_command();
		cmd_done = 1'b1;
		next_command();
	endtask

	task automatic sysex_beat(input logic [7:0] b);
		logic [8:0] used;
		logic       at_eox;
		logic       at_limit;
		used     = {1'b0, sysex_pos} + 9'd1;
		at_eox   = (b == STAT_EOX);
		at_limit = (used >= SYSEX_LIMIT);
		// a run that eats the last section byte without its end marker is dropped
		if (!at_eox && sect_left == 12'd0) begin
			drop_packet();
			return;
		end
		if (!at_eox && at_limit)
			used = used + 9'd1;
		push_event(RK_SYSEX, STAT_SYSEX, 5'd0, used[7:0], {7'd0, used[8]}, used[7:0],
			b, sysex_pos, at_eox || at_limit);
		if (at_eox) begin
			finish_command();
		end else if (at_limit) begin
			phase = PH_SKIP;
		end else begin
			sysex_pos = used[7:0];
			phase = PH_SYSEX;
		end
	endtask

	task automatic decode_rtp_byte(input rtpm_in_t beat);
		logic [7:0] b;
		logic [2:0] cls;
		logic [7:0] mtype;
		logic [4:0] ch;
		b = beat.data_byte;
		if (beat.packet_start) begin
			phase      = PH_HEADER;
			hdr_pos    = 5'd0;
			cmd_done   = 1'b0;
			sect_left  = 12'd0;
			sect_flags = 8'd0;
		end
		case (phase)
			PH_HEADER: begin
				if (hdr_pos == HEADER_BYTES) begin
					sect_flags = b;
					sect_left = {8'd0, b[3:0]};
					if ((b & FLAG_B) != 8'd0)
						phase = PH_LENLOW;
					else
						next_command();
				end else begin
					if (hdr_pos >= STAMP_FIRST && hdr_pos <= STAMP_LAST)
						rtp_stamp = {rtp_stamp[23:0], b};
					hdr_pos = hdr_pos + 5'd1;
				end
			end
			PH_LENLOW: begin
				sect_left = {sect_left[3:0], b};
				next_command();
			end
			PH_DELTA: begin
				sect_left = sect_left - 12'd1;
				delta_len = delta_len + 3'd1;
				if (!b[7] || delta_len >= DELTA_MAX)
					phase = (sect_left == 12'd0) ? PH_IDLE : PH_CMD;
				else if (sect_left == 12'd0)
					drop_packet();
			end
			PH_CMD: begin
				sect_left = sect_left - 12'd1;
				status_byte = b;
				cls = status_class(b);
				if (cls == CLS_BAD) begin
					drop_packet();
				end else if (cls == CLS_SYSEX) begin
					sysex_pos = 8'd0;
					sysex_beat(b);
				end else if (cls == CLS_NONE) begin
					push_event(RK_MSG, b, 5'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0);
					finish_command();
				end else if ({9'd0, cls} > sect_left) begin
					drop_packet();
				end else begin
					data_left = cls[1:0];
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				sect_left = sect_left - 12'd1;
				if (status_byte < STAT_SYSEX) begin
					mtype = {status_byte[7:4], 4'h0};
					ch = {1'b0, status_byte[3:0]} + 5'd1;
				end else begin
					mtype = status_byte;
					ch = 5'd0;
				end
				if (data_left >= 2'd2) begin
					first_data = b;
					data_left = 2'd1;
				end else begin
					data_left = 2'd0;
					if (status_class(status_byte) == CLS_TWO)
						push_event(RK_MSG, mtype, ch, first_data, b, 8'd3, 8'd0, 8'd0, 1'b0);
					else
						push_event(RK_MSG, mtype, ch, b, 8'd0, 8'd2, 8'd0, 8'd0, 1'b0);
					finish_command();
				end
			end
			PH_SYSEX: begin
				sect_left = sect_left - 12'd1;
				sysex_beat(b);
			end
			PH_SKIP: begin
				sect_left = sect_left - 12'd1;
				finish_command();
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rtpm_out_t want;
		if (!arst_n) begin
			phase       = PH_IDLE;
			hdr_pos     = 5'd0;
			sect_flags  = 8'd0;
			sect_left   = 12'd0;
			delta_len   = 3'd0;
			status_byte = 8'd0;
			first_data  = 8'd0;
			data_left   = 2'd0;
			rtp_stamp   = 32'd0;
			cmd_done    = 1'b0;
			sysex_pos   = 8'd0;
			errs        = 0;
			midi_events_due.delete();
		end else begin
			if (item_valid && !item_stall)
				decode_rtp_byte(item);
			if (result_valid && !result_stall) begin
				if (midi_events_due.size() == 0) begin
					$error("result beat with no event due: kind %0d type 0x%0h",
						result.result_kind, result.msg_type);
					errs++;
				end else begin
					want = midi_events_due.pop_front();
					check_field("result_kind", 32'(want.result_kind),
						32'(result.result_kind));
					check_field("msg_type", 32'(want.msg_type), 32'(result.msg_type));
					check_field("channel", 32'(want.channel), 32'(result.channel));
					check_field("data_one", 32'(want.data_one), 32'(result.data_one));
					check_field("data_two", 32'(want.data_two), 32'(result.data_two));
					check_field("byte_count", 32'(want.byte_count),
						32'(result.byte_count));
					check_field("stamp", want.stamp, result.stamp);
					check_field("sysex_byte", 32'(want.sysex_byte),
						32'(result.sysex_byte));
					check_field("sysex_index", 32'(want.sysex_index),
						32'(result.sysex_index));
					check_field("sysex_end", 32'(want.sysex_end), 32'(result.sysex_end));
				end
			end
		end
		mismatches <= errs;
		events_due <= midi_events_due.size();
	end

endmodule

// File: test/rtp_midi_command_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP-MIDI command parser testbench
// Feeds whole packets byte by byte: a few hand-built ones, then random
// packets that are mostly well formed, with some cut short, mis-sized or
// carrying bad status bytes. Both channels idle at random; the checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module rtp_midi_command_parser_test;
	import rtpm_pkg::*;

	localparam int BYTE_TARGET  = 1800;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int STAMP_FIRST  = 4;

	// header bits the parser ignores, toggled at random
	localparam logic [7:0] SPARE_FLAGS = 8'h50;
	localparam logic [7:0] DELTA_MORE  = 8'h80;

	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_PITCH    = 4'hE;
	localparam logic [7:0] ST_MTC       = 8'hF1;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
	localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
	localparam logic [7:0] ST_TUNE      = 8'hF6;
	localparam logic [7:0] ST_CLOCK     = 8'hF8;
	localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
	localparam logic [7:0] ST_START     = 8'hFA;
	localparam logic [7:0] ST_CONT      = 8'hFB;
	localparam logic [7:0] ST_STOP      = 8'hFC;
	localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;
	localparam logic [7:0] ST_SENSE     = 8'hFE;
	localparam logic [7:0] ST_RESET     = 8'hFF;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	rtpm_in_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	rtpm_out_t result;

	int   mismatches;
	int   events_due;
	int   cycle_count = 0;
	int   bytes_sent  = 0;
	int   stall_run   = 0;
	logic gaps_on     = 1'b0;

	// command-section content of the packet being built, then the whole packet
	logic [7:0] body[$];
	logic [7:0] pkt[$];

	rtp_midi_command_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	rtp_midi_command_parser_check parse_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.events_due   (events_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop, well beyond the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rtp_midi_command_parser_test: errors");
			$finish;
		end
	end

	// Receiver back-pressure: long open runs, short stalls, now and then a long one
	always @(posedge clk) begin : result_stall_gen
		int unsigned mode;
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				result_stall <= 1'b0;
				stall_run <= $urandom_range(1, 30);
			end else if (mode < 9) begin
				result_stall <= 1'b1;
				stall_run <= $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				stall_run <= $urandom_range(10, 40);
			end
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Data byte: mostly 7-bit, sometimes with bit 7 set (the parser takes it as is)
	function automatic logic [7:0] data_value();
		if ($urandom_range(0, 4) != 0)
			return 8'($urandom_range(0, 127));
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one beat and hold it until taken; keep valid high into the next beat
	// unless a gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic first);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, packet_start: first};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Wrap the section in an RTP header and send it; cut > 0 truncates the packet
	task automatic send_packet(input logic [31:0] ts, input logic zflag,
		input logic [11:0] sect_len, input logic wide, input int cut);
		logic [7:0] hdr;
		int         stop;
		pkt.delete();
		for (int i = 0; i < RTPM_HEADER_BYTES; i++)
			pkt.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < 4; i++)
			pkt[STAMP_FIRST + i] = ts[31 - 8 * i -: 8];
		hdr = (8'($urandom) & SPARE_FLAGS) | (wide ? FLAG_B : 8'h00)
			| (zflag ? FLAG_Z : 8'h00) | {4'h0, wide ? sect_len[11:8] : sect_len[3:0]};
		pkt.push_back(hdr);
		if (wide)
			pkt.push_back(sect_len[7:0]);
		foreach (body[i])
			pkt.push_back(body[i]);
		// trailing bytes: ignored after the section, or eaten by an oversized length
		repeat ($urandom_range(0, 3))
			pkt.push_back(8'($urandom_range(0, 255)));
		stop = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < stop; i++)
			send_byte(pkt[i], i == 0);
	endtask

	// Delta time of 1 to 4 bytes; the 4th byte ends it whatever its bit 7
	task automatic add_delta();
		int n;
		n = $urandom_range(1, DELTA_MAX);
		for (int i = 1; i < n; i++)
			body.push_back(DELTA_MORE | 8'($urandom_range(0, 127)));
		if (n == DELTA_MAX)
			body.push_back(8'($urandom_range(0, 255)));
		else
			body.push_back(8'($urandom_range(0, 127)));
	endtask

	// SysEx run: mostly short, rarely one that fills the store exactly, ending
	// either on the end marker in the last slot or at the limit with a skipped byte
	task automatic add_sysex();
		int         n;
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(0, 19);
		body.push_back(STAT_SYSEX);
		if (pick == 0)
			n = RTPM_SYSEX_LIMIT - 2;
		else if (pick == 1)
			n = RTPM_SYSEX_LIMIT - 1;
		else
			n = $urandom_range(0, 8);
		repeat (n) begin
			b = data_value();
			if (b == STAT_EOX)
				b = 8'h7F;
			body.push_back(b);
		end
		if (pick == 1)
			body.push_back(8'($urandom_range(0, 255)));
		else
			body.push_back(STAT_EOX);
	endtask

	task automatic add_command();
		int         pick;
		logic [7:0] st;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
			body.push_back(st);
			repeat ((st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 1 : 2)
				body.push_back(data_value());
		end else if (pick < 62) begin
			case ($urandom_range(0, 2))
				0:       st = ST_MTC;
				1:       st = ST_SONG_SEL;
				default: st = ST_SONG_POS;
			endcase
			body.push_back(st);
			repeat ((st == ST_SONG_POS) ? 2 : 1)
				body.push_back(data_value());
		end else if (pick < 74) begin
			case ($urandom_range(0, 6))
				0:       st = ST_TUNE;
				1:       st = ST_CLOCK;
				2:       st = ST_START;
				3:       st = ST_CONT;
				4:       st = ST_STOP;
				5:       st = ST_SENSE;
				default: st = ST_RESET;
			endcase
			body.push_back(st);
		end else if (pick < 92) begin
			add_sysex();
		end else begin
			// bad status: a data byte where a status belongs, or an undefined one
			case ($urandom_range(0, 5))
				0:       st = ST_UNDEF_F4;
				1:       st = ST_UNDEF_F5;
				2:       st = STAT_EOX;
				3:       st = ST_UNDEF_F9;
				4:       st = ST_UNDEF_FD;
				default: st = 8'($urandom_range(0, 127));
			endcase
			body.push_back(st);
		end
	endtask

	// Mostly exact lengths; some short (aborts or quiet ends), empty, oversized
	// or huge, and now and then a packet cut off by the next start
	task automatic random_packet();
		logic zflag;
		logic wide;
		int   ncmd;
		int   sect_len;
		int   pick;
		int   cut;
		body.delete();
		zflag = 1'($urandom_range(0, 1));
		ncmd = $urandom_range(1, 6);
		for (int i = 0; i < ncmd; i++) begin
			if (i > 0 || zflag)
				add_delta();
			add_command();
		end
		if ($urandom_range(0, 5) == 0)
			add_delta();
		sect_len = body.size();
		pick = $urandom_range(0, 39);
		if (pick < 4)
			sect_len = $urandom_range(0, sect_len - 1);
		else if (pick < 6)
			sect_len = 0;
		else if (pick < 8)
			sect_len = sect_len + $urandom_range(1, 4);
		else if (pick == 8)
			sect_len = $urandom_range(16, 4095);
		if (sect_len > 4095)
			sect_len = 4095;
		wide = (sect_len > 15) || ($urandom_range(0, 1) != 0);
		cut = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 14) : 0;
		send_packet($urandom(), zflag, 12'(sect_len), wide, cut);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Stray bytes before any packet start: ignore
		send_byte(ST_RESET, 1'b0);
		send_byte(8'h00, 1'b0);

		// Short-form length, no leading delta: note on, program change, a full
		// 4-byte delta, clock, song position with extreme data
		body = '{{NIB_NOTE_ON, 4'h0}, 8'h3C, 8'h7F, 8'h00, {NIB_PROGRAM, 4'hF}, 8'h12,
			8'h81, 8'h80, 8'h80, 8'hFF, ST_CLOCK, 8'h7F, ST_SONG_POS, 8'h00, 8'hFF};
		send_packet(32'h0000_0000, 1'b0, 12'(body.size()), 1'b0, 0);

		// Long-form length of zero: empty section
		body.delete();
		send_packet(32'hFFFF_FFFF, 1'b1, 12'd0, 1'b1, 0);

		// Leading delta, short sysex run, then an undefined status drops the packet
		body = '{8'h00, STAT_SYSEX, 8'h01, 8'h02, STAT_EOX, 8'h00, ST_UNDEF_F4, ST_CLOCK};
		send_packet($urandom(), 1'b1, 12'(body.size()), 1'b1, 0);

		// Pitch bend whose data would run past the length
		body = '{{NIB_PITCH, 4'h3}, 8'h00};
		send_packet($urandom(), 1'b0, 12'd2, 1'b0, 0);

		// SysEx run that uses up the length before its end marker
		body = '{STAT_SYSEX, 8'h01, 8'h02, 8'h03};
		send_packet($urandom(), 1'b0, 12'd3, 1'b0, 0);

		while (bytes_sent < BYTE_TARGET)
			random_packet();
		item_valid <= 1'b0;

		// Let the checker see the last prediction, then drain
		@(posedge clk);
		while (events_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("rtp_midi_command_parser_test: clean");
		else
			$display("rtp_midi_command_parser_test: errors");
		$finish;
	end

endmodule

// File: files.f
sv/rtpm_pkg.sv
sv/rtpm_in_stage.sv
sv/rtpm_parser.sv
sv/rtpm_out_stage.sv
sv/rtp_midi_command_parser.sv
test/rtp_midi_command_parser_check.sv
test/rtp_midi_command_parser_test.sv
